// ----- design/brz_pkg.sv -----
// ----------------------------------------------------------------------------
// brz_pkg
// Shared constants, codes and controller/datapath types for the bilinear
// resize block.
// ----------------------------------------------------------------------------
package brz_pkg;

  // Storage sizes
  localparam int IMAGE_BYTES  = 4096;
  localparam int MAX_OUT_DIM  = 256;
  localparam int MAX_CHANNELS = 16;
  localparam int IMG_AW       = $clog2(IMAGE_BYTES);
  localparam int TBL_AW       = $clog2(MAX_OUT_DIM);
  localparam int TBL_W        = 34;

  // Fixed point: Q10 weights, products rounded by 2^19 and scaled by 2^20
  localparam int Q_FRAC   = 10;
  localparam int SCALE_SH = 20;
  localparam int ROUND    = 1 << 19;

  // Input operation codes
  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_COL    = 2'd1,
    OP_ROW    = 2'd2,
    OP_PIXEL  = 2'd3
  } opcode_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_WIDTH_ZERO  = 2'd1,
    ST_RANGE       = 2'd2
  } status_t;

  // Configuration register indexes
  localparam logic [1:0] REG_IN_WIDTH = 2'd0;
  localparam logic [1:0] REG_CHANNELS = 2'd1;
  localparam logic [1:0] REG_OUT_WIDTH = 2'd2;

  // Controller states, one-hot
  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_DIV  = 9'b000000010,
    S_CHK  = 9'b000000100,
    S_TBL  = 9'b000001000,
    S_WGT  = 9'b000010000,
    S_BASE = 9'b000100000,
    S_RD   = 9'b001000000,
    S_MAC  = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       accept;
    logic       div_step;
    logic       wgt;
    logic       base;
    logic       scale;
    logic       rd;
    logic       mac;
    logic       fin;
    logic       emit_ow;
    logic       emit_rng;
    logic [1:0] tap;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic ow_zero;
    logic bad_range;
    logic no_chan;
    logic last_chan;
  } sts_t;

endpackage

// ----- design/brz_ram.sv -----
// ----------------------------------------------------------------------------
// brz_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module brz_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/brz_ctrl.sv -----
// ----------------------------------------------------------------------------
// brz_ctrl
// Sequencer: index division, table lookup, weight setup, then four tap
// reads and multiply-accumulates per channel.
// ----------------------------------------------------------------------------
module brz_ctrl
  import brz_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] opcode,
  input  sts_t       sts,
  output cmd_t       cmd,
  output logic       busy
);

  state_t     state, state_next;
  logic [3:0] div_cnt;
  logic [1:0] tap;
  logic       accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.accept   = accept;
    cmd.tap      = tap;
    unique case (state)
      S_IDLE: begin
        if (accept && (opcode == OP_PIXEL)) begin
          if (sts.ow_zero) begin
            cmd.emit_ow = 1'b1;
          end else begin
            state_next = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (div_cnt == 4'hF) begin
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (sts.bad_range) begin
          cmd.emit_rng = 1'b1;
          state_next   = S_IDLE;
        end else begin
          state_next = S_TBL;
        end
      end
      S_TBL: begin
        cmd.wgt    = 1'b1;
        state_next = S_WGT;
      end
      S_WGT: begin
        cmd.base   = 1'b1;
        state_next = S_BASE;
      end
      S_BASE: begin
        cmd.scale  = 1'b1;
        state_next = sts.no_chan ? S_IDLE : S_RD;
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_MAC;
      end
      S_MAC: begin
        cmd.mac    = 1'b1;
        state_next = (tap == 2'd3) ? S_FIN : S_RD;
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = sts.last_chan ? S_IDLE : S_RD;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State, division step count and tap index
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      div_cnt <= '0;
      tap     <= '0;
    end else begin
      state <= state_next;
      if (state == S_DIV) begin
        div_cnt <= div_cnt + 4'd1;
      end else begin
        div_cnt <= '0;
      end
      if (state == S_MAC) begin
        tap <= tap + 2'd1;
      end else if (state != S_RD) begin
        tap <= '0;
      end
    end
  end

endmodule

// ----- design/brz_dp.sv -----
// ----------------------------------------------------------------------------
// brz_dp
// Datapath: image store and axis tables, restoring divider, Q10 weights,
// tap addresses, multiply-accumulate, rounding and result register.
// ----------------------------------------------------------------------------
module brz_dp
  import brz_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [8:0]         in_width,
  input  logic [4:0]         channel_count,
  input  logic [8:0]         out_width,
  input  logic [1:0]         opcode,
  input  logic [11:0]        image_addr,
  input  logic signed [7:0]  sample,
  input  logic [7:0]         table_index,
  input  logic [7:0]         lower_pos,
  input  logic [7:0]         upper_pos,
  input  logic [17:0]        scaled_pos,
  input  logic [15:0]        pixel_index,
  output logic signed [7:0]  value,
  output logic [1:0]         status,
  output logic               last,
  output logic               out_valid
);

  // Memories
  logic [TBL_W-1:0]  col_rd, row_rd, tbl_wdata;
  logic [7:0]        img_rd;
  logic [IMG_AW-1:0] img_raddr;

  // Divider
  logic [15:0] quo;
  logic [8:0]  rem;
  logic [9:0]  rem_sh;
  logic        rem_ge;

  // Weights and addresses
  logic [7:0]         clo, chi;
  logic [16:0]        rlo_w, rhi_w;
  logic signed [19:0] wx, wy, ox, oy;
  logic signed [39:0] coef [4];
  logic [17:0]        base [4];
  logic [22:0]        taddr [4];
  logic [22:0]        addr_sum;
  logic [4:0]         chan;
  logic [3:0]         ch_idx;
  logic               oob;

  // Accumulate and round
  logic signed [7:0]  smp;
  logic signed [47:0] prod;
  logic signed [49:0] acc, rnd, adj;
  logic signed [29:0] quot;
  logic signed [7:0]  sat;

  assign tbl_wdata = {lower_pos, upper_pos, scaled_pos};

  brz_ram #(.WIDTH(8), .DEPTH(IMAGE_BYTES)) u_img (
    .clk   (clk),
    .we    (cmd.accept && (opcode == OP_SAMPLE)),
    .waddr (image_addr[IMG_AW-1:0]),
    .wdata (sample),
    .raddr (img_raddr),
    .rdata (img_rd)
  );

  brz_ram #(.WIDTH(TBL_W), .DEPTH(MAX_OUT_DIM)) u_col (
    .clk   (clk),
    .we    (cmd.accept && (opcode == OP_COL)),
    .waddr (table_index[TBL_AW-1:0]),
    .wdata (tbl_wdata),
    .raddr (rem[TBL_AW-1:0]),
    .rdata (col_rd)
  );

  brz_ram #(.WIDTH(TBL_W), .DEPTH(MAX_OUT_DIM)) u_row (
    .clk   (clk),
    .we    (cmd.accept && (opcode == OP_ROW)),
    .waddr (table_index[TBL_AW-1:0]),
    .wdata (tbl_wdata),
    .raddr (quo[TBL_AW-1:0]),
    .rdata (row_rd)
  );

  // Channel count limited to the store's maximum
  assign chan = (channel_count > 5'(MAX_CHANNELS)) ? 5'(MAX_CHANNELS) : channel_count;

  // Status to controller
  assign sts.ow_zero   = (out_width == 9'd0);
  assign sts.bad_range = (quo[15:TBL_AW] != '0) || rem[8];
  assign sts.no_chan   = (chan == 5'd0);
  assign sts.last_chan = (({1'b0, ch_idx} + 5'd1) == chan);

  // Divider step: shift in one dividend bit, subtract when it fits
  assign rem_sh = {rem, quo[15]};
  assign rem_ge = (rem_sh >= {1'b0, out_width});

  // Complementary weights
  assign ox = 20'sd1024 - wx;
  assign oy = 20'sd1024 - wy;

  // Tap address and sample
  assign addr_sum  = taddr[cmd.tap] + 23'(ch_idx);
  assign img_raddr = addr_sum[IMG_AW-1:0];
  assign smp       = oob ? 8'sd0 : $signed(img_rd);
  assign prod      = 48'(coef[cmd.tap]) * 48'(smp);

  // Round half up, then truncate toward zero
  assign rnd  = acc + 50'(ROUND);
  assign adj  = rnd + (rnd[49] ? 50'((1 << SCALE_SH) - 1) : 50'sd0);
  assign quot = 30'(adj >>> SCALE_SH);
  always_comb begin
    if (quot > 30'sd127) begin
      sat = 8'sd127;
    end else if (quot < -30'sd128) begin
      sat = -8'sd128;
    end else begin
      sat = quot[7:0];
    end
  end

  // Divider registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      quo <= pixel_index;
      rem <= '0;
    end else if (cmd.div_step) begin
      quo <= {quo[14:0], rem_ge};
      rem <= rem_ge ? 9'(rem_sh - {1'b0, out_width}) : rem_sh[8:0];
    end
  end

  // Weight, base and address pipeline
  always_ff @(posedge clk) begin
    if (cmd.wgt) begin
      wx    <= $signed({2'b00, col_rd[17:0]}) - $signed({2'b00, col_rd[33:26], 10'b0});
      wy    <= $signed({2'b00, row_rd[17:0]}) - $signed({2'b00, row_rd[33:26], 10'b0});
      clo   <= col_rd[33:26];
      chi   <= col_rd[25:18];
      rlo_w <= 17'(row_rd[33:26]) * 17'(in_width);
      rhi_w <= 17'(row_rd[25:18]) * 17'(in_width);
    end
    if (cmd.base) begin
      coef[0] <= 40'(ox) * 40'(oy);
      coef[1] <= 40'(wy) * 40'(ox);
      coef[2] <= 40'(wx) * 40'(oy);
      coef[3] <= 40'(wx) * 40'(wy);
      base[0] <= 18'(rlo_w) + 18'(clo);
      base[1] <= 18'(rhi_w) + 18'(clo);
      base[2] <= 18'(rlo_w) + 18'(chi);
      base[3] <= 18'(rhi_w) + 18'(chi);
    end
    if (cmd.scale) begin
      for (int i = 0; i < 4; i++) begin
        taddr[i] <= 23'(base[i]) * 23'(chan);
      end
    end
    if (cmd.rd) begin
      oob <= (addr_sum[22:IMG_AW] != '0);
    end
  end

  // Accumulator and channel index
  always_ff @(posedge clk) begin
    if (cmd.rd && (cmd.tap == 2'd0)) begin
      acc <= '0;
    end else if (cmd.mac) begin
      acc <= acc + 50'(prod);
    end
    if (cmd.scale) begin
      ch_idx <= '0;
    end else if (cmd.fin) begin
      ch_idx <= ch_idx + 4'd1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.fin || cmd.emit_ow || cmd.emit_rng;
    end
    if (cmd.fin) begin
      value  <= sat;
      status <= ST_OK;
      last   <= sts.last_chan;
    end else if (cmd.emit_ow || cmd.emit_rng) begin
      value  <= 8'sd0;
      status <= cmd.emit_ow ? ST_WIDTH_ZERO : ST_RANGE;
      last   <= 1'b1;
    end
  end

endmodule

// ----- design/bilinear_resize_int8_fixed.sv -----
// ----------------------------------------------------------------------------
// bilinear_resize_int8_fixed
// Top level: configuration registers on the APB-style port, sequencer and
// datapath of the int8 bilinear resize.
// ----------------------------------------------------------------------------
// Load transactions leave busy low.
// A pixel transaction (up to 16 channels) runs a 16-step restoring divider,
// table read and weight setup, then four serial image store reads with
// multiply-accumulate and one result per channel. Results cannot be stalled.
// Reset clears control and sets in_width, channel_count and out_width to 1;
// stores are not cleared.
module bilinear_resize_int8_fixed
  import brz_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        opcode,
  input  logic [11:0]       image_addr,
  input  logic signed [7:0] sample,
  input  logic [7:0]        table_index,
  input  logic [7:0]        lower_pos,
  input  logic [7:0]        upper_pos,
  input  logic [17:0]       scaled_pos,
  input  logic [15:0]       pixel_index,
  output logic              out_valid,
  output logic signed [7:0] value,
  output logic [1:0]        status,
  output logic              last,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [8:0] in_width;
  logic [4:0] channel_count;
  logic [8:0] out_width;
  cmd_t       cmd;
  sts_t       sts;

  assign pready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      in_width      <= 9'd1;
      channel_count <= 5'd1;
      out_width     <= 9'd1;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_IN_WIDTH:  in_width      <= pwdata[8:0];
        REG_CHANNELS:  channel_count <= pwdata[4:0];
        REG_OUT_WIDTH: out_width     <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (paddr[3:2])
      REG_IN_WIDTH:  prdata = {23'd0, in_width};
      REG_CHANNELS:  prdata = {27'd0, channel_count};
      REG_OUT_WIDTH: prdata = {23'd0, out_width};
      default:       prdata = '0;
    endcase
  end

  brz_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  brz_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .in_width      (in_width),
    .channel_count (channel_count),
    .out_width     (out_width),
    .opcode        (opcode),
    .image_addr    (image_addr),
    .sample        (sample),
    .table_index   (table_index),
    .lower_pos     (lower_pos),
    .upper_pos     (upper_pos),
    .scaled_pos    (scaled_pos),
    .pixel_index   (pixel_index),
    .value         (value),
    .status        (status),
    .last          (last),
    .out_valid     (out_valid)
  );

endmodule

// ----- design/brz_checker.sv -----
// ----------------------------------------------------------------------------
// brz_checker
// Port-level checks on the bilinear resize top level, bound to it.
// ----------------------------------------------------------------------------
module brz_checker
  import brz_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] opcode,
  input logic       out_valid,
  input logic [1:0] status,
  input logic       last
);

  // Error results are always single, closing transactions
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> last)
    else $error("error result without last");

  // Only defined status codes appear
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_WIDTH_ZERO || status == ST_RANGE))
    else $error("undefined status code");

  // A load transaction produces no result
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (opcode != OP_PIXEL) |=> !out_valid)
    else $error("result after load");

  // More channels pending keeps the block busy
  a_more_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |=> busy)
    else $error("idle with channels pending");

endmodule

bind bilinear_resize_int8_fixed brz_checker u_brz_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .opcode    (opcode),
  .out_valid (out_valid),
  .status    (status),
  .last      (last)
);
